@@ rtl/core/tmeu_pkg.sv @@
package tmeu_pkg;

  // tape size must be a power of two, pointer arithmetic wraps in TAPE_AW bits
  localparam int TAPE_CELLS    = 65536;
  localparam int PROGRAM_WORDS = 65536;
  localparam int TAPE_AW       = $clog2(TAPE_CELLS);

  localparam int ADDR_W = 16;
  localparam int REP_W  = 16;
  localparam int BYTE_W = 8;
  localparam int PLEN_W = 17;
  localparam int NEXT_W = 17;

  localparam int PW_W    = $clog2(PROGRAM_WORDS + 1);
  localparam int LIMIT_W = (PLEN_W > PW_W) ? PLEN_W : PW_W;

  typedef enum logic [2:0] {
    KIND_BACK    = 3'd0,
    KIND_FORWARD = 3'd1,
    KIND_INC     = 3'd2,
    KIND_DEC     = 3'd3,
    KIND_READ    = 3'd4,
    KIND_WRITE   = 3'd5,
    KIND_LOOP_LO = 3'd6,
    KIND_LOOP_HI = 3'd7
  } kind_t;

endpackage

@@ rtl/core/tmeu_if.sv @@
interface tmeu_in_if;
  import tmeu_pkg::*;

  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [REP_W-1:0]  repeats;
  logic [ADDR_W-1:0] jump_target;
  logic [ADDR_W-1:0] instr_addr;
  logic [BYTE_W-1:0] in_byte;

  modport source (
    output valid, kind, repeats, jump_target, instr_addr, in_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, repeats, jump_target, instr_addr, in_byte,
    output ready
  );
endinterface

interface tmeu_out_if;
  import tmeu_pkg::*;

  logic              valid;
  logic              ready;
  logic [NEXT_W-1:0] next_addr;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              halted;

  modport source (
    output valid, next_addr, out_valid, out_byte, halted,
    input  ready
  );
  modport sink (
    input  valid, next_addr, out_valid, out_byte, halted,
    output ready
  );
endinterface

@@ rtl/core/tmeu_ram.sv @@
module tmeu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tape_machine_execute_unit.sv @@
// Tape machine execute unit: runs one pre-decoded, run-length encoded
// instruction per request on the in_req channel and returns one result per
// request on out_rsp (next instruction address, emitted byte, halt flag).
// The user must write program_length through cfg_we/cfg_wdata only while
// the unit is idle; the block itself does not enforce it. A request taken
// on in_req executes from the input register and its result is registered
// in the output register. While the output does not stall, one request is
// taken per cycle: the current tape cell is kept in a register, and after a
// pointer move the tape RAM is read at the new pointer in the same cycle, so
// the next instruction has its cell ready. The tape is a single-port-write,
// registered-read RAM of TAPE_CELLS bytes. After reset the unit sweeps the
// tape to zero, one cell a cycle; in_req.ready stays low during that sweep,
// while configuration writes are taken. Pointer, program length reset to 0.
// When out_rsp.ready is low the result holds in the output register; one
// more request is taken into an empty input register, then ready drops.
module tape_machine_execute_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  tmeu_in_if.sink                     in_req,
  tmeu_out_if.source                  out_rsp,
  input  logic                        cfg_we,
  input  logic [tmeu_pkg::PLEN_W-1:0] cfg_wdata
);
  import tmeu_pkg::*;

  // config
  logic [PLEN_W-1:0] plen_r;

  // clearing sweep
  logic               clearing_r;
  logic [TAPE_AW-1:0] clr_addr_r;

  // input register
  logic              s1_vld_r;
  kind_t             s1_kind_r;
  logic [REP_W-1:0]  s1_rep_r;
  logic [ADDR_W-1:0] s1_tgt_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // machine state
  logic [TAPE_AW-1:0] dp_r, dp_nxt;
  logic [BYTE_W-1:0]  cell_r, cell_nxt;
  logic               use_mem_r, use_mem_nxt;

  // output register
  logic              out_vld_r;
  logic [NEXT_W-1:0] next_r;
  logic              ovld_r;
  logic [BYTE_W-1:0] obyte_r;
  logic              halt_r;

  logic               exec;
  logic               accept;
  logic [BYTE_W-1:0]  cell_cur;
  logic [BYTE_W-1:0]  cell_new;
  logic               cell_wr;
  logic [TAPE_AW-1:0] step;
  logic [NEXT_W-1:0]  next_val;
  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] plen_ext;
  logic               halt_val;
  logic [BYTE_W-1:0]  ram_rdata;
  logic               ram_we;
  logic [TAPE_AW-1:0] ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;

  assign exec   = s1_vld_r && (!out_vld_r || out_rsp.ready);
  assign accept = in_req.valid && in_req.ready;

  assign in_req.ready = !clearing_r && (!s1_vld_r || exec);

  // after a move the cell comes from the ram read issued at the new pointer
  assign cell_cur = use_mem_r ? ram_rdata : cell_r;
  assign step     = TAPE_AW'(s1_rep_r);

  always_comb begin
    dp_nxt   = dp_r;
    cell_new = cell_cur;
    cell_wr  = 1'b0;
    next_val = NEXT_W'(s1_addr_r) + NEXT_W'(1);
    if (exec) begin
      case (s1_kind_r)
        KIND_BACK:    dp_nxt = dp_r - step;
        KIND_FORWARD: dp_nxt = dp_r + step;
        KIND_INC: begin
          cell_new = cell_cur + s1_rep_r[BYTE_W-1:0];
          cell_wr  = 1'b1;
        end
        KIND_DEC: begin
          cell_new = cell_cur - s1_rep_r[BYTE_W-1:0];
          cell_wr  = 1'b1;
        end
        KIND_READ: begin
          cell_new = s1_byte_r;
          cell_wr  = 1'b1;
        end
        KIND_WRITE: ;
        KIND_LOOP_LO: begin
          if (cell_cur == '0) next_val = NEXT_W'(s1_tgt_r) + NEXT_W'(1);
        end
        KIND_LOOP_HI: begin
          if (cell_cur != '0) next_val = NEXT_W'(s1_tgt_r) + NEXT_W'(1);
        end
        default: ;
      endcase
    end
  end

  assign cell_nxt    = cell_new;
  assign use_mem_nxt = exec && (s1_kind_r == KIND_BACK || s1_kind_r == KIND_FORWARD);

  assign plen_ext = LIMIT_W'(plen_r);
  assign limit    = (plen_ext > LIMIT_W'(PROGRAM_WORDS)) ? LIMIT_W'(PROGRAM_WORDS) : plen_ext;
  assign halt_val = LIMIT_W'(next_val) >= limit;

  assign ram_we    = clearing_r || cell_wr;
  assign ram_waddr = clearing_r ? clr_addr_r : dp_r;
  assign ram_wdata = clearing_r ? '0 : cell_new;

  tmeu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (dp_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r     <= '0;
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      s1_vld_r   <= 1'b0;
      dp_r       <= '0;
      cell_r     <= '0;
      use_mem_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) plen_r <= cfg_wdata;
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + TAPE_AW'(1);
        if (clr_addr_r == TAPE_AW'(TAPE_CELLS - 1)) clearing_r <= 1'b0;
      end
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (exec) begin
        s1_vld_r <= 1'b0;
      end
      dp_r      <= dp_nxt;
      cell_r    <= cell_nxt;
      use_mem_r <= use_mem_nxt;
      if (exec) begin
        out_vld_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= in_req.kind;
      s1_rep_r  <= in_req.repeats;
      s1_tgt_r  <= in_req.jump_target;
      s1_addr_r <= in_req.instr_addr;
      s1_byte_r <= in_req.in_byte;
    end
    if (exec) begin
      next_r  <= next_val;
      ovld_r  <= (s1_kind_r == KIND_WRITE);
      obyte_r <= (s1_kind_r == KIND_WRITE) ? cell_cur : '0;
      halt_r  <= halt_val;
    end
  end

  assign out_rsp.valid     = out_vld_r;
  assign out_rsp.next_addr = next_r;
  assign out_rsp.out_valid = ovld_r;
  assign out_rsp.out_byte  = obyte_r;
  assign out_rsp.halted    = halt_r;

  // no request may enter or execute while the tape is being swept
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_req.ready && !exec)
    else $error("request taken during tape clear");

  // a stalled request stays in the input register
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !exec) |=> s1_vld_r && $stable(s1_addr_r))
    else $error("stalled request lost");

  // write output always produces an emitting result
  a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && s1_kind_r == KIND_WRITE) |=> out_rsp.valid && out_rsp.out_valid)
    else $error("write output result missing");

  // the pointer only changes on a move
  a_dp_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !(exec && (s1_kind_r == KIND_BACK || s1_kind_r == KIND_FORWARD)) |=> $stable(dp_r))
    else $error("data pointer changed without a move");

endmodule
